// ----- design/atcp_pkg.sv -----
package atcp_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_IDX_W  = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_LEN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CMD_LEN   = 1'd1;

  localparam logic [BYTE_W-1:0] MAX_FRAME_LEN_RST = 8'd250;
  localparam logic [BYTE_W-1:0] MAX_CMD_LEN_RST   = 8'd10;

  // Characters
  localparam logic [BYTE_W-1:0] CH_A     = 8'h41;
  localparam logic [BYTE_W-1:0] CH_T     = 8'h54;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_EQ    = 8'h3D;
  localparam logic [BYTE_W-1:0] CH_QMARK = 8'h3F;

  localparam logic [BYTE_W-1:0] FRAME_LEN_MAX = 8'd255;
  localparam logic [BYTE_W-1:0] AT_LEN        = 8'd2;

  typedef enum logic [1:0] {
    KIND_NAME = 2'd0,
    KIND_ARG  = 2'd1,
    KIND_END  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    TYPE_EXEC  = 2'd0,
    TYPE_QUERY = 2'd1,
    TYPE_SET   = 2'd2,
    TYPE_TEST  = 2'd3
  } cmd_type_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BAD   = 2'd1,
    ST_NLNUL = 2'd2,
    ST_OVF   = 2'd3
  } status_t;

  typedef enum logic [6:0] {
    PH_PLUS = 7'b0000001,
    PH_NAME = 7'b0000010,
    PH_EQ   = 7'b0000100,
    PH_EQQ  = 7'b0001000,
    PH_Q    = 7'b0010000,
    PH_ARGS = 7'b0100000,
    PH_DROP = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] max_frame_len;
    logic [BYTE_W-1:0] max_cmd_len;
  } cfg_t;

  typedef struct packed {
    kind_t             item_kind;
    logic [BYTE_W-1:0] char_value;
    cmd_type_t         command_type;
    status_t           status;
    logic [BYTE_W-1:0] frame_length;
  } result_t;

endpackage

// ----- design/atcp_if.sv -----
interface atcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface atcp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] item_kind;
  logic [7:0] char_value;
  logic [1:0] command_type;
  logic [1:0] status;
  logic [7:0] frame_length;

  modport source (output valid, output item_kind, output char_value, output command_type,
                  output status, output frame_length, input ready);
  modport sink   (input valid, input item_kind, input char_value, input command_type,
                  input status, input frame_length, output ready);
endinterface

// ----- design/atcp_parser.sv -----
module atcp_parser import atcp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              byte_valid,
  input  logic [BYTE_W-1:0] byte_data,
  output logic              byte_ready,
  output logic              res_valid,
  output result_t           res_data,
  input  logic              res_ready
);

  logic              byte_v_r;
  logic [BYTE_W-1:0] byte_r;
  logic              step;

  logic              active_r,   active_nxt;
  logic [BYTE_W-1:0] prev_r,     prev_nxt;
  logic [BYTE_W-1:0] cnt_r,      cnt_nxt;
  phase_t            phase_r,    phase_nxt;
  logic [BYTE_W-1:0] name_cnt_r, name_cnt_nxt;
  status_t           pstat_r,    pstat_nxt;
  cmd_type_t         ptype_r,    ptype_nxt;

  logic [BYTE_W-1:0] cnt_inc;
  logic              end_frame;
  status_t           end_status;
  cmd_type_t         end_type;

  assign step       = byte_v_r && res_ready;
  assign byte_ready = !byte_v_r || step;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_v_r <= 1'b0;
    end else if (byte_ready) begin
      byte_v_r <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_ready && byte_valid) begin
      byte_r <= byte_data;
    end
  end

  assign cnt_inc = (cnt_r == FRAME_LEN_MAX) ? cnt_r : cnt_r + 8'd1;

  always_comb begin
    active_nxt   = active_r;
    prev_nxt     = prev_r;
    cnt_nxt      = cnt_r;
    phase_nxt    = phase_r;
    name_cnt_nxt = name_cnt_r;
    pstat_nxt    = pstat_r;
    ptype_nxt    = ptype_r;
    res_valid    = 1'b0;
    res_data     = '0;
    end_frame    = 1'b0;
    end_status   = ST_OK;
    end_type     = ptype_r;

    if (step) begin
      prev_nxt = byte_r;
      if (!active_r) begin
        if (prev_r == CH_A && byte_r == CH_T) begin
          active_nxt   = 1'b1;
          cnt_nxt      = AT_LEN;
          phase_nxt    = PH_PLUS;
          name_cnt_nxt = '0;
          pstat_nxt    = ST_OK;
          ptype_nxt    = TYPE_EXEC;
        end
      end else begin
        cnt_nxt = cnt_inc;
        if (byte_r == CH_CR) begin
          end_frame  = 1'b1;
          end_status = pstat_r;
          unique case (phase_r)
            PH_NAME: end_type = TYPE_EXEC;
            PH_Q:    end_type = TYPE_QUERY;
            PH_EQQ:  end_type = TYPE_TEST;
            PH_ARGS: end_type = TYPE_SET;
            default: end_status = ST_BAD;
          endcase
        end else if (byte_r == CH_LF || byte_r == CH_NUL) begin
          end_frame  = 1'b1;
          end_status = ST_NLNUL;
        end else if (cnt_inc >= cfg.max_frame_len) begin
          end_frame  = 1'b1;
          end_status = ST_OVF;
        end else begin
          unique case (phase_r)
            PH_PLUS: begin
              if (byte_r == CH_PLUS) begin
                phase_nxt = PH_NAME;
              end else begin
                phase_nxt = PH_DROP;
                pstat_nxt = ST_BAD;
              end
            end
            PH_NAME: begin
              if (byte_r == CH_EQ) begin
                phase_nxt = PH_EQ;
              end else if (byte_r == CH_QMARK) begin
                phase_nxt = PH_Q;
              end else if (name_cnt_r >= cfg.max_cmd_len) begin
                phase_nxt = PH_DROP;
                pstat_nxt = ST_BAD;
              end else begin
                name_cnt_nxt        = name_cnt_r + 8'd1;
                res_valid           = 1'b1;
                res_data.item_kind  = KIND_NAME;
                res_data.char_value = byte_r;
              end
            end
            PH_EQ: begin
              if (byte_r == CH_QMARK) begin
                phase_nxt = PH_EQQ;
              end else begin
                ptype_nxt           = TYPE_SET;
                phase_nxt           = PH_ARGS;
                res_valid           = 1'b1;
                res_data.item_kind  = KIND_ARG;
                res_data.char_value = byte_r;
              end
            end
            PH_ARGS: begin
              res_valid           = 1'b1;
              res_data.item_kind  = KIND_ARG;
              res_data.char_value = byte_r;
            end
            PH_EQQ, PH_Q: begin
              phase_nxt = PH_DROP;
              pstat_nxt = ST_BAD;
            end
            default: begin
              phase_nxt = phase_r;
            end
          endcase
        end

        if (end_frame) begin
          res_valid             = 1'b1;
          res_data.item_kind    = KIND_END;
          res_data.status       = end_status;
          res_data.command_type = (end_status == ST_OK) ? end_type : TYPE_EXEC;
          res_data.frame_length = cnt_inc;
          active_nxt   = 1'b0;
          cnt_nxt      = '0;
          phase_nxt    = PH_PLUS;
          name_cnt_nxt = '0;
          pstat_nxt    = ST_OK;
          ptype_nxt    = TYPE_EXEC;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      prev_r     <= '0;
      cnt_r      <= '0;
      phase_r    <= PH_PLUS;
      name_cnt_r <= '0;
      pstat_r    <= ST_OK;
      ptype_r    <= TYPE_EXEC;
    end else begin
      active_r   <= active_nxt;
      prev_r     <= prev_nxt;
      cnt_r      <= cnt_nxt;
      phase_r    <= phase_nxt;
      name_cnt_r <= name_cnt_nxt;
      pstat_r    <= pstat_nxt;
      ptype_r    <= ptype_nxt;
    end
  end

endmodule

// ----- design/atcp_out_reg.sv -----
module atcp_out_reg import atcp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push_valid,
  input  result_t push_data,
  output logic    push_ready,
  output logic    out_valid,
  output result_t out_data,
  input  logic    out_ready
);

  logic    main_v_r;
  result_t main_r;
  logic    skid_v_r;
  result_t skid_r;

  assign push_ready = !skid_v_r;
  assign out_valid  = main_v_r;
  assign out_data   = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!main_v_r || out_ready) begin
      if (skid_v_r) begin
        main_v_r <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        main_v_r <= push_valid;
      end
    end else if (push_valid && !skid_v_r) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_v_r || out_ready) begin
      main_r <= skid_v_r ? skid_r : push_data;
    end else if (push_valid && !skid_v_r) begin
      skid_r <= push_data;
    end
  end

endmodule

// ----- design/at_command_stream_parser_core.sv -----
// AT command stream parser. Feed received bytes on in_rx, one byte per
// transfer; the block hunts for "AT" (the pair may span transfers and may start
// with the last byte of the previous frame), then frames the command up to the
// carriage return. Command-name characters (kind 0) and set-command argument
// characters (kind 1) stream out on out_res as they arrive; one end report
// (kind 2) closes every frame with command type, status and frame length.
// On a status other than ok, discard the characters already taken for that
// frame. Throughput is one byte per clock while out_res is ready: a byte passes
// an input register, the compare/counter logic of the parser, and a two-entry
// output register (main plus skid), whose main entry drives out_res. The
// configuration registers (index 0 max_frame_len, reset 250; index 1
// max_cmd_len, reset 10) are written through cfg_we / cfg_index / cfg_wdata
// and must only change while the block is idle.
module at_command_stream_parser_core import atcp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  atcp_in_if.sink              in_rx,
  atcp_out_if.source           out_res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_wdata
);

  cfg_t    cfg_r;
  logic    res_valid;
  result_t res_data;
  logic    res_ready;
  logic    out_valid;
  result_t out_data;

  // Configuration registers: write by index, no read-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_frame_len <= MAX_FRAME_LEN_RST;
      cfg_r.max_cmd_len   <= MAX_CMD_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_FRAME_LEN: cfg_r.max_frame_len <= cfg_wdata;
        CFG_MAX_CMD_LEN:   cfg_r.max_cmd_len   <= cfg_wdata;
        default:           cfg_r <= cfg_r;
      endcase
    end
  end

  // Hold the byte in the input register and advance the frame state
  atcp_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .byte_valid (in_rx.valid),
    .byte_data  (in_rx.rx_byte),
    .byte_ready (in_rx.ready),
    .res_valid  (res_valid),
    .res_data   (res_data),
    .res_ready  (res_ready)
  );

  // Result register with skid entry so a stalled consumer never drops a transfer
  atcp_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (res_valid),
    .push_data  (res_data),
    .push_ready (res_ready),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .out_ready  (out_res.ready)
  );

  assign out_res.valid        = out_valid;
  assign out_res.item_kind    = out_data.item_kind;
  assign out_res.char_value   = out_data.char_value;
  assign out_res.command_type = out_data.command_type;
  assign out_res.status       = out_data.status;
  assign out_res.frame_length = out_data.frame_length;

endmodule
